### hw/rtl/ccpb_pkg.sv
// shared types for the closed contour perimeter and bounding box block
// controller states, command and status groups; no dependencies
package ccpb_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_ACCUM,
      ST_WAIT_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic closing;
      logic sq_x;
      logic sq_y;
      logic root_step;
      logic accum;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic last;
      logic root_done;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/ccpb_ctrl.sv
// sequencer for the perimeter and bounding box block
// steps each segment through difference, squares, root and accumulate; uses ccpb_pkg
module ccpb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_point,
   output logic                 req_stall,
   input  ccpb_pkg::status_type status,
   output ccpb_pkg::cmd_type    cmd
);
   import ccpb_pkg::*;

   state_type state_ff, state_in;
   logic      closing_ff, closing_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         closing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         closing_ff <= closing_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      closing_in = closing_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.started) begin
                  state_in   = ST_DIFF;
                  closing_in = 1'b0;
               end else if (req_last_point) begin
                  state_in   = ST_DIFF;
                  closing_in = 1'b1;
               end
            end
         end
         ST_DIFF:  state_in = ST_SQ_X;
         ST_SQ_X:  state_in = ST_SQ_Y;
         ST_SQ_Y:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (closing_ff) begin
               state_in = ST_WAIT_OUT;
            end else if (status.last) begin
               state_in   = ST_DIFF;
               closing_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WAIT_OUT: begin
            if (status.out_free) begin
               state_in   = ST_IDLE;
               closing_in = 1'b0;
            end
         end
         default: begin
            state_in   = ST_IDLE;
            closing_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.closing   = closing_ff;
      case (state_ff)
         ST_IDLE:     cmd.load      = accept;
         ST_DIFF:     cmd.diff      = 1'b1;
         ST_SQ_X:     cmd.sq_x      = 1'b1;
         ST_SQ_Y:     cmd.sq_y      = 1'b1;
         ST_ROOT:     cmd.root_step = 1'b1;
         ST_ACCUM:    cmd.accum     = 1'b1;
         ST_WAIT_OUT: cmd.emit      = status.out_free;
         default:     cmd           = '0;
      endcase
   end

endmodule

### hw/rtl/ccpb_datapath.sv
// point registers, box, shared squarer, bit-serial square root, saturating
// length accumulator and result register; uses ccpb_pkg
module ccpb_datapath #(
   parameter int COORD_WIDTH  = 16,
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [COORD_WIDTH-1:0]  req_point_x,
   input  logic signed [COORD_WIDTH-1:0]  req_point_y,
   input  logic                           req_last_point,
   input  ccpb_pkg::cmd_type              cmd,
   output ccpb_pkg::status_type           status,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic        [LENGTH_WIDTH-1:0] rsp_perimeter,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_min_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_max_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_min_y,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_max_y,
   output logic                           rsp_length_saturated
);
   import ccpb_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int N    = COORD_WIDTH + 1;
   localparam int CW   = $clog2(N);
   localparam int LW   = LENGTH_WIDTH;
   localparam int SUMW = ((LW > N) ? LW : N) + 1;
   localparam logic [CW-1:0]   LAST_STEP = CW'(N - 1);
   localparam logic [SUMW-1:0] LEN_MAX   = {{(SUMW - LW){1'b0}}, {LW{1'b1}}};

   logic signed [W-1:0] cur_x_ff, cur_y_ff, first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic                last_ff, started_ff, ovf_ff;
   logic [LW-1:0]       len_ff;
   logic [W-1:0]        dx_ff, dy_ff, dx_in, dy_in;
   logic [2*N-1:0]      sum_ff;
   logic [N+1:0]        rem_ff, rem_in, rem_shift, trial;
   logic [N-1:0]        root_ff, root_in;
   logic [CW-1:0]       cnt_ff;
   logic [2*W-1:0]      product;
   logic [W-1:0]        mul_op;
   logic [SUMW-1:0]     len_sum;
   logic                rsp_valid_ff;

   logic signed [W:0]   diff_x, diff_y;
   logic        [W:0]   neg_x, neg_y;
   logic signed [W-1:0] ref_x, ref_y;

   // absolute differences against the previous or the first point
   always_comb begin
      ref_x  = cmd.closing ? first_x_ff : prev_x_ff;
      ref_y  = cmd.closing ? first_y_ff : prev_y_ff;
      diff_x = $signed({cur_x_ff[W-1], cur_x_ff}) - $signed({ref_x[W-1], ref_x});
      diff_y = $signed({cur_y_ff[W-1], cur_y_ff}) - $signed({ref_y[W-1], ref_y});
      neg_x  = -diff_x;
      neg_y  = -diff_y;
      dx_in  = diff_x[W] ? neg_x[W-1:0] : diff_x[W-1:0];
      dy_in  = diff_y[W] ? neg_y[W-1:0] : diff_y[W-1:0];
   end

   assign mul_op  = cmd.sq_x ? dx_ff : dy_ff;
   assign product = mul_op * mul_op;

   // one result bit per step, radicand consumed two bits at a time
   always_comb begin
      rem_shift = {rem_ff[N-1:0], sum_ff[2*N-1 -: 2]};
      trial     = {root_ff, 2'b01};
      if (rem_shift >= trial) begin
         rem_in  = rem_shift - trial;
         root_in = {root_ff[N-2:0], 1'b1};
      end else begin
         rem_in  = rem_shift;
         root_in = {root_ff[N-2:0], 1'b0};
      end
   end

   assign len_sum = SUMW'(len_ff) + SUMW'(root_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         len_ff     <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         min_x_ff   <= '0;
         max_x_ff   <= '0;
         min_y_ff   <= '0;
         max_y_ff   <= '0;
      end else begin
         if (cmd.load) begin
            if (!started_ff) begin
               first_x_ff <= req_point_x;
               first_y_ff <= req_point_y;
               prev_x_ff  <= req_point_x;
               prev_y_ff  <= req_point_y;
               min_x_ff   <= req_point_x;
               max_x_ff   <= req_point_x;
               min_y_ff   <= req_point_y;
               max_y_ff   <= req_point_y;
               len_ff     <= '0;
               ovf_ff     <= 1'b0;
               started_ff <= 1'b1;
            end else begin
               if (req_point_x < min_x_ff) min_x_ff <= req_point_x;
               if (req_point_x > max_x_ff) max_x_ff <= req_point_x;
               if (req_point_y < min_y_ff) min_y_ff <= req_point_y;
               if (req_point_y > max_y_ff) max_y_ff <= req_point_y;
            end
         end
         if (cmd.accum) begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
            if (len_sum > LEN_MAX) begin
               len_ff <= {LW{1'b1}};
               ovf_ff <= 1'b1;
            end else begin
               len_ff <= len_sum[LW-1:0];
            end
         end
         if (cmd.emit) begin
            started_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= req_point_x;
         cur_y_ff <= req_point_y;
         last_ff  <= req_last_point;
      end
      if (cmd.diff) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.sq_x) begin
         sum_ff <= (2*N)'(product);
      end
      if (cmd.sq_y) begin
         sum_ff <= sum_ff + (2*N)'(product);
      end
      if (cmd.root_step) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_ff + 1'b1;
         sum_ff  <= {sum_ff[2*N-3:0], 2'b00};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_perimeter        <= len_ff;
         rsp_box_min_x        <= min_x_ff;
         rsp_box_max_x        <= max_x_ff;
         rsp_box_min_y        <= min_y_ff;
         rsp_box_max_y        <= max_y_ff;
         rsp_length_saturated <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.started   = started_ff;
   assign status.last      = last_ff;
   assign status.root_done = (cnt_ff == LAST_STEP);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a pending transfer");

   a_emit_in_chain: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> started_ff)
      else $error("result emitted outside a chain");

   a_segment_in_chain: assert property (@(posedge clock) disable iff (reset)
      (cmd.sq_x || cmd.sq_y || cmd.root_step || cmd.accum) |-> started_ff)
      else $error("segment work outside a chain");

   a_emit_clears_chain: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (!started_ff && rsp_valid_ff))
      else $error("chain not closed after result");

endmodule

### hw/rtl/closed_contour_perimeter_bbox.sv
// top level of the closed contour perimeter and bounding box block
// joins ccpb_ctrl and ccpb_datapath; uses ccpb_pkg
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  point_x, point_y, last_point
//   rsp_     out        rsp_valid/rsp_stall  perimeter, box min/max x/y, length_saturated
//
// the first point of a chain only opens it; every other point runs one segment through
// difference, squares, the one-bit-per-cycle square root of COORD_WIDTH+1 steps and accumulate
// a last point adds the closing segment and the result write; a one-point chain has only
// the closing segment, and the result write waits for any result stall to end
// synchronous reset clears the chain and the result valid flag
// a new point is taken while a result waits; only writing the next result waits for rsp_stall
module closed_contour_perimeter_bbox #(
   parameter int COORD_WIDTH  = 16,
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_WIDTH-1:0]  req_point_x,
   input  logic signed [COORD_WIDTH-1:0]  req_point_y,
   input  logic                           req_last_point,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic        [LENGTH_WIDTH-1:0] rsp_perimeter,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_min_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_max_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_min_y,
   output logic signed [COORD_WIDTH-1:0]  rsp_box_max_y,
   output logic                           rsp_length_saturated
);
   import ccpb_pkg::*;

   cmd_type    cmd;
   status_type status;

   ccpb_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   ccpb_datapath #(
      .COORD_WIDTH  (COORD_WIDTH),
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_point_x          (req_point_x),
      .req_point_y          (req_point_y),
      .req_last_point       (req_last_point),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_perimeter        (rsp_perimeter),
      .rsp_box_min_x        (rsp_box_min_x),
      .rsp_box_max_x        (rsp_box_max_x),
      .rsp_box_min_y        (rsp_box_min_y),
      .rsp_box_max_y        (rsp_box_max_y),
      .rsp_length_saturated (rsp_length_saturated)
   );

endmodule

### bench/closed_contour_perimeter_bbox_tb.sv
// testbench for closed_contour_perimeter_bbox: edge chains in, perimeter and box out
// predicts each closed contour from its points and checks every result transfer in order
// depends only on the closed_contour_perimeter_bbox rtl
module closed_contour_perimeter_bbox_tb;

   localparam int COORD_W = 16;
   localparam int LENGTH_W = 32;
   localparam longint LENGTH_MAX = (longint'(1) << LENGTH_W) - 1;
   localparam int COORD_MIN = -32768;
   localparam int COORD_MAX = 32767;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int ZIGZAG_POINTS = 101;

   typedef struct packed {
      logic [LENGTH_W-1:0] perimeter;
      logic [COORD_W-1:0]  min_x;
      logic [COORD_W-1:0]  max_x;
      logic [COORD_W-1:0]  min_y;
      logic [COORD_W-1:0]  max_y;
      logic                saturated;
   } contour_summary_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [COORD_W-1:0]   req_point_x = '0;
   logic signed [COORD_W-1:0]   req_point_y = '0;
   logic                        req_last_point = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic        [LENGTH_W-1:0]  rsp_perimeter;
   logic signed [COORD_W-1:0]   rsp_box_min_x;
   logic signed [COORD_W-1:0]   rsp_box_max_x;
   logic signed [COORD_W-1:0]   rsp_box_min_y;
   logic signed [COORD_W-1:0]   rsp_box_max_y;
   logic                        rsp_length_saturated;

   contour_summary_type summary_queue[$];
   int  mismatches = 0;
   int  points_sent = 0;
   bit  sender_idle = 1'b1;
   bit  receiver_idle = 1'b1;

   // contour tracker state
   bit     chain_open = 1'b0;
   int     first_x, first_y, prev_x, prev_y;
   int     box_min_x, box_max_x, box_min_y, box_max_y;
   longint length_sum;
   bit     clamped;

   closed_contour_perimeter_bbox #(
      .COORD_WIDTH (COORD_W),
      .LENGTH_WIDTH(LENGTH_W)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_last_point      (req_last_point),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_perimeter       (rsp_perimeter),
      .rsp_box_min_x       (rsp_box_min_x),
      .rsp_box_max_x       (rsp_box_max_x),
      .rsp_box_min_y       (rsp_box_min_y),
      .rsp_box_max_y       (rsp_box_max_y),
      .rsp_length_saturated(rsp_length_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint segment_length(input longint dx, input longint dy);
      longint sq;
      longint root;
      longint trial;
      sq = dx * dx + dy * dy;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= sq) root = trial;
      end
      return root;
   endfunction

   function automatic void add_segment(input int ax, input int ay, input int bx, input int by);
      length_sum = length_sum + segment_length(ax - bx, ay - by);
      if (length_sum > LENGTH_MAX) begin
         length_sum = LENGTH_MAX;
         clamped = 1'b1;
      end
   endfunction

   function automatic bit trace_point(input int x, input int y, input bit last,
                                      output contour_summary_type summary);
      if (!chain_open) begin
         first_x = x;
         first_y = y;
         prev_x = x;
         prev_y = y;
         box_min_x = x;
         box_max_x = x;
         box_min_y = y;
         box_max_y = y;
         length_sum = 0;
         clamped = 1'b0;
         chain_open = 1'b1;
      end else begin
         add_segment(x, y, prev_x, prev_y);
         if (x < box_min_x) box_min_x = x;
         if (x > box_max_x) box_max_x = x;
         if (y < box_min_y) box_min_y = y;
         if (y > box_max_y) box_max_y = y;
         prev_x = x;
         prev_y = y;
      end
      summary = '0;
      if (!last) return 1'b0;
      // closing segment back to the first point
      add_segment(first_x, first_y, x, y);
      summary.perimeter = length_sum[LENGTH_W-1:0];
      summary.min_x = box_min_x[COORD_W-1:0];
      summary.max_x = box_max_x[COORD_W-1:0];
      summary.min_y = box_min_y[COORD_W-1:0];
      summary.max_y = box_max_y[COORD_W-1:0];
      summary.saturated = clamped;
      chain_open = 1'b0;
      return 1'b1;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_cycles(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_point(input int x, input int y, input bit last);
      int gap;
      contour_summary_type summary;
      gap = idle_cycles(sender_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x[COORD_W-1:0];
      req_point_y <= y[COORD_W-1:0];
      req_last_point <= last;
      do @(posedge clock); while (req_stall);
      if (trace_point(x, y, last, summary)) summary_queue.push_back(summary);
      points_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (summary_queue.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [LENGTH_W-1:0] want,
                                input logic [LENGTH_W-1:0] got);
      if (want !== got) begin
         $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      contour_summary_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (summary_queue.size() == 0) begin
            $display("%0t result transfer: expected none, got perimeter %0h", $time,
                     rsp_perimeter);
            mismatches++;
         end else begin
            want = summary_queue.pop_front();
            compare_field("perimeter", want.perimeter, rsp_perimeter);
            compare_field("box_min_x", {16'b0, want.min_x}, {16'b0, rsp_box_min_x});
            compare_field("box_max_x", {16'b0, want.max_x}, {16'b0, rsp_box_max_x});
            compare_field("box_min_y", {16'b0, want.min_y}, {16'b0, rsp_box_min_y});
            compare_field("box_max_y", {16'b0, want.max_y}, {16'b0, rsp_box_max_y});
            compare_field("length_saturated", {31'b0, want.saturated},
                          {31'b0, rsp_length_saturated});
         end
      end
   end

   // result side stalls
   initial begin : rsp_pacing
      int run;
      int hold;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
         hold = idle_cycles(receiver_idle);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   task automatic test_directed_contours();
      // single point chains at both corners
      send_point(COORD_MIN, COORD_MIN, 1'b1);
      send_point(COORD_MAX, COORD_MAX, 1'b1);
      // two point chains go out and back
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b1);
      send_point(0, 0, 1'b0);
      send_point(48, 64, 1'b1);
      // square
      send_point(0, 0, 1'b0);
      send_point(160, 0, 1'b0);
      send_point(160, 160, 1'b0);
      send_point(0, 160, 1'b1);
      // alternating bit patterns
      send_point(21845, -21846, 1'b0);
      send_point(-21846, 21845, 1'b0);
      send_point(-1, 0, 1'b0);
      send_point(0, -1, 1'b1);
      // coincident points
      send_point(100, -100, 1'b0);
      send_point(100, -100, 1'b1);
      // opposite corners
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b1);
      wait_for_results();
   endtask

   // zigzag across the full range, largest segments back to back
   task automatic test_long_zigzag();
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      for (int i = 0; i < ZIGZAG_POINTS; i++) begin
         if (i % 2 == 0) send_point(COORD_MIN, COORD_MIN, i == ZIGZAG_POINTS - 1);
         else send_point(COORD_MAX, COORD_MAX, 1'b0);
      end
      wait_for_results();
   endtask

   function automatic int pick_coord(input int style, input int center);
      int v;
      case (style)
         0: v = $urandom_range(0, 65535) - 32768;
         1: begin
            v = center + $urandom_range(0, 511) - 256;
            if (v < COORD_MIN) v = COORD_MIN;
            if (v > COORD_MAX) v = COORD_MAX;
         end
         2: begin
            case ($urandom_range(0, 3))
               0: v = COORD_MIN;
               1: v = COORD_MAX;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = center;
      endcase
      return v;
   endfunction

   task automatic test_random_contours(input int target);
      int chain;
      int len;
      int style;
      int cx;
      int cy;
      int r;
      chain = 0;
      while (points_sent < target) begin
         // a stretch of chains with no idling on either side
         sender_idle = (chain % 40) >= 8;
         receiver_idle = (chain % 40) >= 8;
         r = $urandom_range(0, 99);
         if (r < 10) len = 1;
         else if (r < 25) len = 2;
         else if (r < 85) len = $urandom_range(3, 8);
         else len = $urandom_range(9, 30);
         r = $urandom_range(0, 99);
         if (r < 45) style = 0;
         else if (r < 80) style = 1;
         else if (r < 95) style = 2;
         else style = 3;
         cx = $urandom_range(0, 65535) - 32768;
         cy = $urandom_range(0, 65535) - 32768;
         for (int i = 0; i < len; i++)
            send_point(pick_coord(style, cx), pick_coord(style, cy), i == len - 1);
         chain++;
         if (chain % 50 == 25) wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_contours();
      test_long_zigzag();
      test_random_contours(points_sent + 1530);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && summary_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### closed_contour_perimeter_bbox.f
hw/rtl/ccpb_pkg.sv
hw/rtl/ccpb_ctrl.sv
hw/rtl/ccpb_datapath.sv
hw/rtl/closed_contour_perimeter_bbox.sv
bench/closed_contour_perimeter_bbox_tb.sv
